>>> hw/rtl/sobq_pkg.sv
// Shared constants, codes and types for the stack of bounded queues.
// No dependencies; imported by sobq_mem and stack_of_bounded_queues.
`default_nettype none

package sobq_pkg;

    // Sizing
    localparam int QUEUE_CAP  = 3;
    localparam int MAX_QUEUES = 16;

    localparam int ELEM_DEPTH = MAX_QUEUES * QUEUE_CAP;
    localparam int ELEM_AW    = (ELEM_DEPTH > 1) ? $clog2(ELEM_DEPTH) : 1;
    localparam int TOP_W      = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
    localparam int DEPTH_W    = $clog2(MAX_QUEUES + 1);
    localparam int HEAD_W     = (QUEUE_CAP > 1) ? $clog2(QUEUE_CAP) : 1;
    localparam int FILL_W     = $clog2(QUEUE_CAP + 1);
    localparam int SUM_W      = FILL_W + 1;
    localparam int DATA_W     = 32;
    localparam int COUNT_W    = 5;

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Status codes
    localparam logic [1:0] STS_DONE  = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    typedef logic [ELEM_AW-1:0] elem_addr_t;
    typedef logic [TOP_W-1:0]   top_idx_t;
    typedef logic [HEAD_W-1:0]  head_t;
    typedef logic [DATA_W-1:0]  data_t;

    // Requests from the sequencer to the two memories
    typedef struct packed {
        logic       elem_re;
        elem_addr_t elem_raddr;
        logic       elem_we;
        elem_addr_t elem_waddr;
        data_t      elem_wdata;
        logic       head_re;
        top_idx_t   head_raddr;
        logic       head_we;
        top_idx_t   head_waddr;
        head_t      head_wdata;
    } sobq_mem_req_t;

    // Entry of slot s in queue q
    function automatic elem_addr_t elem_addr(input top_idx_t q, input head_t s);
        elem_addr_t a;
        a = ELEM_AW'(q) * ELEM_AW'(QUEUE_CAP) + ELEM_AW'(s);
        return a;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sobq_mem.sv
// Element store and per-queue head-slot store, both synchronous RAMs.
// Depends on sobq_pkg for sizes and the request struct.
`default_nettype none

module sobq_mem
    import sobq_pkg::*;
(
    input  wire logic          clk,
    input  wire sobq_mem_req_t mem_req,
    output logic [DATA_W-1:0]  elem_rdata,
    output logic [HEAD_W-1:0]  head_rdata
);

    logic [DATA_W-1:0] elem_mem [ELEM_DEPTH];
    logic [HEAD_W-1:0] head_mem [MAX_QUEUES];

    // Element store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_req.elem_we)
        begin
            elem_mem[mem_req.elem_waddr] <= mem_req.elem_wdata;
        end
        if (mem_req.elem_re)
        begin
            elem_rdata <= elem_mem[mem_req.elem_raddr];
        end
    end

    // Head-slot store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_req.head_we)
        begin
            head_mem[mem_req.head_waddr] <= mem_req.head_wdata;
        end
        if (mem_req.head_re)
        begin
            head_rdata <= head_mem[mem_req.head_raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/stack_of_bounded_queues.sv
// Top level: stack of small FIFO queues kept in two synchronous RAMs.
// Depends on sobq_pkg and sobq_mem.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  request | req_valid / req_ready | operation, item_value
//  result  | rsp_valid / rsp_ready | status, removed_value, queue_count
//
// For each request, the transfer cycle issues the RAM reads
// (oldest element of the top queue, head slot of the queue below), and the
// execute state then uses the read data and writes back. The result sits
// in an output register, so a new request is taken while it waits; a full
// result register holds the sequencer in its execute state. Reset empties
// the stack; no RAM clearing.
`default_nettype none

module stack_of_bounded_queues
    import sobq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire logic [1:0]          operation,
    input  wire logic signed [31:0]  item_value,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output logic [1:0]               status,
    output logic signed [31:0]       removed_value,
    output logic [COUNT_W-1:0]       queue_count
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                state_reg, state_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    head_t               top_head_reg, top_head_next;
    logic [1:0]          op_reg;
    data_t               value_reg;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [1:0]          status_reg;
    data_t               removed_reg;
    logic [COUNT_W-1:0]  count_reg;

    sobq_mem_req_t       mem_req;
    data_t               elem_rdata;
    head_t               head_rdata;

    logic                req_xfer;
    logic                commit;
    top_idx_t            top_idx;
    top_idx_t            lower_idx;
    top_idx_t            new_idx;
    logic                need_push;
    logic [SUM_W-1:0]    slot_sum;
    head_t               ins_slot;
    logic [HEAD_W:0]     head_inc;
    head_t               head_adv;
    logic [1:0]          status_calc;
    data_t               removed_calc;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_xfer  = req_valid && req_ready;
    assign commit    = (state_reg == ST_EXEC) && (!rsp_valid_reg || rsp_ready);

    assign top_idx   = TOP_W'(depth_reg - DEPTH_W'(1));
    assign lower_idx = TOP_W'(depth_reg - DEPTH_W'(2));
    assign new_idx   = TOP_W'(depth_reg);
    assign need_push = (depth_reg == '0) || (fill_reg == FILL_W'(QUEUE_CAP));

    // Slot behind the newest value of the top queue
    always_comb
    begin
        slot_sum = SUM_W'(top_head_reg) + SUM_W'(fill_reg);
        if (slot_sum >= SUM_W'(QUEUE_CAP))
        begin
            slot_sum = slot_sum - SUM_W'(QUEUE_CAP);
        end
        ins_slot = HEAD_W'(slot_sum);
    end

    // Advance the head slot with wrap
    always_comb
    begin
        head_inc = (HEAD_W + 1)'(top_head_reg) + (HEAD_W + 1)'(1);
        if (head_inc >= (HEAD_W + 1)'(QUEUE_CAP))
        begin
            head_inc = '0;
        end
        head_adv = HEAD_W'(head_inc);
    end

    // Decide the operation and drive RAM requests
    always_comb
    begin
        mem_req            = '0;
        mem_req.elem_re    = req_xfer;
        mem_req.elem_raddr = elem_addr(top_idx, top_head_reg);
        mem_req.elem_waddr = elem_addr(top_idx, ins_slot);
        mem_req.elem_wdata = value_reg;
        mem_req.head_re    = req_xfer;
        mem_req.head_raddr = lower_idx;
        mem_req.head_waddr = top_idx;
        mem_req.head_wdata = head_adv;

        depth_next    = depth_reg;
        fill_next     = fill_reg;
        top_head_next = top_head_reg;
        status_calc   = STS_DONE;
        removed_calc  = '0;

        case (op_reg)
            OP_INSERT:
            begin
                if (need_push)
                begin
                    if (depth_reg >= DEPTH_W'(MAX_QUEUES))
                    begin
                        status_calc = STS_FULL;
                    end
                    else
                    begin
                        // Push a fresh queue and put the value in slot zero
                        mem_req.elem_we    = commit;
                        mem_req.elem_waddr = elem_addr(new_idx, '0);
                        mem_req.head_we    = commit;
                        mem_req.head_waddr = new_idx;
                        mem_req.head_wdata = '0;
                        depth_next         = depth_reg + DEPTH_W'(1);
                        fill_next          = FILL_W'(1);
                        top_head_next      = '0;
                    end
                end
                else
                begin
                    mem_req.elem_we = commit;
                    fill_next       = fill_reg + FILL_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if ((depth_reg == '0) || (fill_reg == '0))
                begin
                    status_calc = STS_EMPTY;
                end
                else
                begin
                    removed_calc = elem_rdata;
                    if (fill_reg == FILL_W'(1))
                    begin
                        // Pop the emptied queue; the one below is full
                        depth_next    = depth_reg - DEPTH_W'(1);
                        fill_next     = (depth_reg != DEPTH_W'(1)) ?
                                        FILL_W'(QUEUE_CAP) : '0;
                        top_head_next = head_rdata;
                    end
                    else
                    begin
                        mem_req.head_we = commit;
                        fill_next       = fill_reg - FILL_W'(1);
                        top_head_next   = head_adv;
                    end
                end
            end
            OP_CLEAR:
            begin
                depth_next = '0;
                fill_next  = '0;
            end
            default:
            begin
                status_calc = STS_DONE;
            end
        endcase
    end

    // Sequencer and result handshake
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            depth_reg     <= '0;
            fill_reg      <= '0;
            top_head_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (commit)
            begin
                depth_reg    <= depth_next;
                fill_reg     <= fill_next;
                top_head_reg <= top_head_next;
            end
        end
    end

    // Request capture and result register
    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            op_reg    <= operation;
            value_reg <= $unsigned(item_value);
        end
        if (commit)
        begin
            status_reg  <= status_calc;
            removed_reg <= removed_calc;
            count_reg   <= COUNT_W'(depth_next);
        end
    end

    sobq_mem u_mem
    (
        .clk        (clk),
        .mem_req    (mem_req),
        .elem_rdata (elem_rdata),
        .head_rdata (head_rdata)
    );

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign removed_value = $signed(removed_reg);
    assign queue_count   = count_reg;

endmodule

`default_nettype wire
